/* hw/rtl/dual_axis_pid_controller_top_macros.svh */
// Assertion helpers for the PID block; they sample on clock and stay quiet in reset.
`ifndef DUAL_AXIS_PID_CONTROLLER_TOP_MACROS_SVH
`define DUAL_AXIS_PID_CONTROLLER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DAPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DAPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dapc_pkg.sv */
package dapc_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 12;
   localparam int TIME_WIDTH_DEF     = 20;

   localparam int GAIN_W        = 16;
   localparam int INTEG_W       = 48;
   localparam int DRIVE_W       = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int US_W          = 20;
   localparam int US_PER_SECOND = 1000000;
   localparam int MAG_CAP_LOG   = 62;
   localparam int DIV_BITS      = 2;

   localparam logic [GAIN_W-1:0] KP_RESET = 16'd4096;
   localparam logic [GAIN_W-1:0] KI_RESET = 16'd410;
   localparam logic [GAIN_W-1:0] KD_RESET = 16'd41;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP = 2'd0,
      CSR_KI = 2'd1,
      CSR_KD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_KI,
      ST_MUL_US,
      ST_DIV_I,
      ST_INT,
      ST_MUL_KD,
      ST_MUL_M,
      ST_DIV_D,
      ST_DER,
      ST_MUL_KP,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/dual_axis_pid_controller_top.sv */
// Channel   Direction  Handshake             Beat contents
// req       in         req_valid/req_stall   two setpoints, two measurements, elapsed_us
// rsp       out        rsp_valid/rsp_stall   pitch_drive, height_drive
// csr       in         csr_we                csr_index, csr_wdata (Kp, Ki, Kd)
//
// An item holds the block until ST_DONE passes its result on; the next req beat is taken
// back in ST_IDLE. Products are P = SAMPLE_WIDTH + 17 + max(TIME_WIDTH, 20) bits wide.
// Each axis runs the 2-bit-per-cycle divider twice, for its integral and derivative terms.
// One multiplier is shared by all terms of both axes; the divider by the I and D terms.
// Reset is synchronous; it restores the gain defaults and clears integrals and last errors.
// A finished result waits in the output register; a second one waits in ST_DONE while
// rsp_stall is high. req_stall is high in every state but ST_IDLE.
`include "dual_axis_pid_controller_top_macros.svh"

module dual_axis_pid_controller_top #(
   parameter int SAMPLE_WIDTH   = dapc_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = dapc_pkg::GAIN_FRAC_BITS_DEF,
   parameter int TIME_WIDTH     = dapc_pkg::TIME_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_pitch_setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_height_setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_pitch_measured,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_height_measured,
   input  logic        [TIME_WIDTH-1:0]         req_elapsed_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dapc_pkg::DRIVE_W-1:0]  rsp_pitch_drive,
   output logic signed [dapc_pkg::DRIVE_W-1:0]  rsp_height_drive,
   input  logic                                 csr_we,
   input  logic        [dapc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [dapc_pkg::GAIN_W-1:0]   csr_wdata
);
   import dapc_pkg::*;

   localparam int ERR_W     = SAMPLE_WIDTH + 1;
   localparam int DIFF_W    = SAMPLE_WIDTH + 2;
   localparam int MAG_W     = SAMPLE_WIDTH + 1;
   localparam int A_W       = GAIN_W + MAG_W;
   localparam int B_W       = (TIME_WIDTH > US_W) ? TIME_WIDTH : US_W;
   localparam int P_W       = A_W + B_W;
   localparam int DIV_W     = ((P_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int DIV_STEPS = DIV_W / DIV_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int TERM_W    = MAG_CAP_LOG + 1;
   localparam int WIDE_W    = (DIV_W > TERM_W) ? DIV_W : TERM_W;
   localparam int SUM_W     = TERM_W + 3;

   localparam logic [CNT_W-1:0]        DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [B_W-1:0]          US_DEN   = B_W'(US_PER_SECOND);
   localparam logic [TERM_W-1:0]       MAG_CAP  = TERM_W'(1) << MAG_CAP_LOG;
   localparam logic signed [SUM_W-1:0] INTEG_HI = SUM_W'({(INTEG_W-1){1'b1}});
   localparam logic signed [SUM_W-1:0] INTEG_LO = ~INTEG_HI;
   localparam logic signed [SUM_W-1:0] DRIVE_HI = SUM_W'({(DRIVE_W-1){1'b1}});
   localparam logic signed [SUM_W-1:0] DRIVE_LO = ~DRIVE_HI;

   function automatic logic signed [SUM_W-1:0] apply_sign(input logic [SUM_W-1:0] mag,
                                                          input logic neg);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   state_type                 state_ff, state_in;
   logic                      ch_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [GAIN_W-1:0]         kp_ff, ki_ff, kd_ff;
   logic signed [ERR_W-1:0]   err_ff [2];
   logic signed [ERR_W-1:0]   last_ff [2];
   logic signed [INTEG_W-1:0] integ_ff [2];
   logic signed [DRIVE_W-1:0] hold_ff [2];
   logic [B_W-1:0]            us_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic [P_W-1:0]            prod_ff;
   logic [DIV_W-1:0]          num_ff;
   logic [B_W:0]              rem_ff;
   logic [B_W-1:0]            den_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_pitch_ff, rsp_height_ff;

   logic signed [ERR_W-1:0]   err_p_in, err_h_in, cur_err, cur_last;
   logic signed [INTEG_W-1:0] cur_integ;
   logic [B_W-1:0]            us_in;
   logic                      err_neg, diff_neg;
   logic [MAG_W-1:0]          err_mag, diff_mag;
   logic [DIFF_W-1:0]         diff_abs;
   logic signed [DIFF_W-1:0]  diff_in;
   logic [A_W-1:0]            mul_a;
   logic [B_W-1:0]            mul_b;
   logic [P_W-1:0]            mul_p;
   logic [DIV_W-1:0]          div_num_nx;
   logic [B_W:0]              div_rem_nx;
   logic [WIDE_W-1:0]         quo_wide;
   logic [TERM_W-1:0]         term_mag;
   logic signed [SUM_W-1:0]   inc_s, integ_sum, deriv_s, acc_in, prop_s, total, shifted;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      out_load;

   // per-beat errors and time, zero time counts as one microsecond
   assign err_p_in = ERR_W'(req_pitch_setpoint) - ERR_W'(req_pitch_measured);
   assign err_h_in = ERR_W'(req_height_setpoint) - ERR_W'(req_height_measured);
   assign us_in    = (req_elapsed_us == '0) ? B_W'(1) : B_W'(req_elapsed_us);

   assign cur_err   = err_ff[ch_ff];
   assign cur_last  = last_ff[ch_ff];
   assign cur_integ = integ_ff[ch_ff];
   assign err_neg   = cur_err[ERR_W-1];
   assign err_mag   = MAG_W'(err_neg ? -cur_err : cur_err);
   assign diff_in   = DIFF_W'(cur_err) - DIFF_W'(cur_last);
   assign diff_neg  = diff_ff[DIFF_W-1];
   assign diff_abs  = diff_neg ? -diff_ff : diff_ff;
   assign diff_mag  = diff_abs[MAG_W-1:0];

   assign mul_p = mul_a * mul_b;

   // radix-4 restoring divider step
   always_comb begin
      div_num_nx = num_ff;
      div_rem_nx = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         div_rem_nx = {div_rem_nx[B_W-1:0], div_num_nx[DIV_W-1]};
         div_num_nx = {div_num_nx[DIV_W-2:0], 1'b0};
         if (div_rem_nx >= {1'b0, den_ff}) begin
            div_rem_nx    = div_rem_nx - {1'b0, den_ff};
            div_num_nx[0] = 1'b1;
         end
      end
   end

   assign quo_wide = WIDE_W'(num_ff);
   assign term_mag = (quo_wide > WIDE_W'(MAG_CAP)) ? MAG_CAP : TERM_W'(quo_wide);

   assign inc_s     = apply_sign(SUM_W'(term_mag), err_neg);
   assign integ_sum = SUM_W'(cur_integ) + inc_s;
   assign integ_in  = (integ_sum > INTEG_HI) ? INTEG_W'(INTEG_HI) :
                      (integ_sum < INTEG_LO) ? INTEG_W'(INTEG_LO) : INTEG_W'(integ_sum);

   assign deriv_s = apply_sign(SUM_W'(term_mag), diff_neg);
   assign acc_in  = SUM_W'(cur_integ) + deriv_s;

   assign prop_s   = apply_sign(SUM_W'(prod_ff[A_W-1:0]), err_neg);
   assign total    = acc_ff + prop_s;
   assign shifted  = total >>> GAIN_FRAC_BITS;
   assign drive_in = (shifted > DRIVE_HI) ? DRIVE_W'(DRIVE_HI) :
                     (shifted < DRIVE_LO) ? DRIVE_W'(DRIVE_LO) : DRIVE_W'(shifted);

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL_KI;
         ST_MUL_KI: state_in = ST_MUL_US;
         ST_MUL_US: state_in = ST_DIV_I;
         ST_DIV_I:  if (cnt_ff == DIV_LAST) state_in = ST_INT;
         ST_INT:    state_in = ST_MUL_KD;
         ST_MUL_KD: state_in = ST_MUL_M;
         ST_MUL_M:  state_in = ST_DIV_D;
         ST_DIV_D:  if (cnt_ff == DIV_LAST) state_in = ST_DER;
         ST_DER:    state_in = ST_MUL_KP;
         ST_MUL_KP: state_in = ST_SUM;
         ST_SUM:    state_in = ch_ff ? ST_DONE : ST_MUL_KI;
         ST_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake and multiplier operands
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_a     = A_W'(err_mag);
      mul_b     = B_W'(kp_ff);
      unique case (state_ff)
         ST_MUL_KI: begin
            mul_a = A_W'(err_mag);
            mul_b = B_W'(ki_ff);
         end
         ST_MUL_US: begin
            mul_a = prod_ff[A_W-1:0];
            mul_b = us_ff;
         end
         ST_MUL_KD: begin
            mul_a = A_W'(diff_mag);
            mul_b = B_W'(kd_ff);
         end
         ST_MUL_M: begin
            mul_a = prod_ff[A_W-1:0];
            mul_b = US_DEN;
         end
         default: begin
            mul_a = A_W'(err_mag);
            mul_b = B_W'(kp_ff);
         end
      endcase
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         cnt_ff       <= '0;
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         integ_ff[0]  <= '0;
         integ_ff[1]  <= '0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_KP:  kp_ff <= csr_wdata;
               CSR_KI:  ki_ff <= csr_wdata;
               CSR_KD:  kd_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff) inside
            ST_MUL_US, ST_MUL_M: cnt_ff <= '0;
            ST_DIV_I, ST_DIV_D:  cnt_ff <= cnt_ff + CNT_W'(1);
            ST_INT:              integ_ff[ch_ff] <= integ_in;
            ST_SUM: begin
               last_ff[ch_ff] <= cur_err;
               ch_ff          <= ~ch_ff;
            end
            default: ;
         endcase
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               err_ff[0] <= err_p_in;
               err_ff[1] <= err_h_in;
               us_ff     <= us_in;
            end
         end
         ST_MUL_KI: begin
            prod_ff <= mul_p;
            diff_ff <= diff_in;
         end
         ST_MUL_KD, ST_MUL_KP: prod_ff <= mul_p;
         ST_MUL_US, ST_MUL_M: begin
            num_ff <= DIV_W'(mul_p);
            rem_ff <= '0;
            den_ff <= (state_ff == ST_MUL_US) ? US_DEN : us_ff;
         end
         ST_DIV_I, ST_DIV_D: begin
            num_ff <= div_num_nx;
            rem_ff <= div_rem_nx;
         end
         ST_DER: acc_ff <= acc_in;
         ST_SUM: hold_ff[ch_ff] <= drive_in;
         default: ;
      endcase
      if (out_load) begin
         rsp_pitch_ff  <= hold_ff[0];
         rsp_height_ff <= hold_ff[1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pitch_drive  = rsp_pitch_ff;
   assign rsp_height_drive = rsp_height_ff;

   `DAPC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted beat did not raise stall")
   `DAPC_ASSERT_SAME(a_div_count_range, state_ff == ST_DIV_I || state_ff == ST_DIV_D, cnt_ff <= DIV_LAST, "divider count overran")
   `DAPC_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result raised outside completion")
   `DAPC_ASSERT_SAME(a_idle_on_pitch, state_ff == ST_IDLE, !ch_ff, "axis select not back on pitch when idle")

endmodule
